// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check that an implication holds at every clock edge out of reset
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// check that a condition leads to a property on the next edge
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// ===== rtl/core/gn3d_pkg.sv =====
// Package for the 3D gradient noise block: constants and the gradient helper function
package gn3d_pkg;

    localparam int TABLE_SIZE_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // input tdata layout
    localparam int IN_W = 1 + 8 + 8 + 32 * 3;
    localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;

    // gradient pick from the low four hash bits
    function automatic logic signed [34:0] grad_pick(
        input logic [3:0] h,
        input logic signed [33:0] x,
        input logic signed [33:0] y,
        input logic signed [33:0] z
    );
        logic signed [33:0] u;
        logic signed [33:0] v;
        logic signed [34:0] su;
        logic signed [34:0] sv;
        begin
            u = (h < 4'd8) ? x : y;
            v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
            su = h[0] ? -35'(u) : 35'(u);
            sv = h[1] ? -35'(v) : 35'(v);
            grad_pick = su + sv;
        end
    endfunction

endpackage

// ===== rtl/core/gradient_noise_3d.sv =====
// Top level of the pipelined 3D improved gradient noise block
`include "assert_macros.svh"

// Fully pipelined 3D gradient noise: one item enters per cycle while the output
// is not stalled, and the result of an evaluate item passes through a chain of
// ten register stages: fade multiplies, three dependent permutation lookups
// (each a registered read of a replicated table copy), gradient picks and
// three blend levels. Each table copy serves one lookup level, and a load item
// writes each copy when it reaches that level, so loads and evaluates mixed back
// to back act strictly in order. Load items give no result. A stall holds the
// entire pipe; results keep their order.
module gradient_noise_3d
#(
    parameter int TABLE_SIZE = gn3d_pkg::TABLE_SIZE_DEF,
    parameter int FRAC_BITS  = gn3d_pkg::FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: table_index[7:0], table_value[15:8], coord_x[47:16],
    // coord_y[79:48], coord_z[111:80]
    input  logic [gn3d_pkg::IN_BYTES_W-8-1:0] s_tdata,
    // tuser: cmd
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: noise_value[FRAC_BITS+2:0], zero filled to whole bytes
    output logic [((FRAC_BITS + 3 + 7) / 8) * 8 - 1:0] m_tdata
);
    import gn3d_pkg::*;

    localparam int TW    = $clog2(TABLE_SIZE);
    localparam int NST   = 10;
    localparam int GS    = 5;
    localparam int NW    = FRAC_BITS + 3;
    localparam int OUT_W = ((NW + 7) / 8) * 8;
    localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;
    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

    typedef logic signed [33:0] fx_t;
    typedef logic [TW-1:0] idx_t;

    // pipeline advance: hold when output is full and not taken
    logic adv;
    logic [NST-1:0] vld_reg;
    assign adv = !vld_reg[NST-1] || m_tready;
    assign s_tready = adv;

    logic in_acc;
    assign in_acc = s_tvalid && s_tready;

    // unpack
    logic [7:0]  in_tidx, in_tval;
    logic [31:0] in_x, in_y, in_z;
    assign in_tidx = s_tdata[7:0];
    assign in_tval = s_tdata[15:8];
    assign in_x    = s_tdata[47:16];
    assign in_y    = s_tdata[79:48];
    assign in_z    = s_tdata[111:80];

    // permutation table copies: level A (cx), level B (a, b), level C (aa..bb)
    logic [7:0] tab_a  [TABLE_SIZE];
    logic [7:0] tab_b0 [TABLE_SIZE];
    logic [7:0] tab_b1 [TABLE_SIZE];
    logic [7:0] tab_c0 [TABLE_SIZE];
    logic [7:0] tab_c1 [TABLE_SIZE];
    logic [7:0] tab_c2 [TABLE_SIZE];
    logic [7:0] tab_c3 [TABLE_SIZE];
    logic wr_en;
    idx_t wr_idx;
    assign wr_en  = in_acc && (s_tuser == CMD_LOAD);
    assign wr_idx = TW'(in_tidx);

    // load delay line: carries each load on to the level B writes and, further down, the level C writes
    logic [3:0] ld_en_reg;
    idx_t       ld_idx_reg [4];
    logic [7:0] ld_val_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ld_en_reg <= '0;
        else if (adv)
            ld_en_reg <= {ld_en_reg[2:0], wr_en};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ld_idx_reg[0] <= wr_idx;
            ld_val_reg[0] <= in_tval;
            for (int s = 1; s < 4; s++)
            begin
                ld_idx_reg[s] <= ld_idx_reg[s-1];
                ld_val_reg[s] <= ld_val_reg[s-1];
            end
        end
    end

    // table writes, each copy when the load reaches its lookup level
    always_ff @(posedge clk)
    begin
        if (wr_en)
            tab_a[wr_idx] <= in_tval;
        if (adv && ld_en_reg[1])
        begin
            tab_b0[ld_idx_reg[1]] <= ld_val_reg[1];
            tab_b1[ld_idx_reg[1]] <= ld_val_reg[1];
        end
        if (adv && ld_en_reg[3])
        begin
            tab_c0[ld_idx_reg[3]] <= ld_val_reg[3];
            tab_c1[ld_idx_reg[3]] <= ld_val_reg[3];
            tab_c2[ld_idx_reg[3]] <= ld_val_reg[3];
            tab_c3[ld_idx_reg[3]] <= ld_val_reg[3];
        end
    end

    // valid chain
    logic ev_in;
    assign ev_in = in_acc && (s_tuser == CMD_EVAL);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], ev_in};
    end

    // fractional parts and fades, per axis
    fx_t  fr_reg [GS+1][3];
    idx_t cell_reg [4][3];
    logic [FRAC_BITS-1:0] frac_in [3];
    idx_t cell_in [3];
    assign frac_in[0] = in_x[FRAC_BITS-1:0];
    assign frac_in[1] = in_y[FRAC_BITS-1:0];
    assign frac_in[2] = in_z[FRAC_BITS-1:0];
    assign cell_in[0] = TW'($signed(in_x) >>> FRAC_BITS);
    assign cell_in[1] = TW'($signed(in_y) >>> FRAC_BITS);
    assign cell_in[2] = TW'($signed(in_z) >>> FRAC_BITS);

    // fade pipe: s1 t2, s2 inner & t3, s3 fade product, s4 round & cap
    logic [47:0] t2_reg [3];
    logic [47:0] t3_reg [3];
    logic [47:0] inner_reg [3];
    logic [63:0] fp_reg [3];
    fx_t fade_reg [GS+1][3];

    logic [63:0] sq_c [3];
    logic [63:0] cu_c [3];
    logic [63:0] in_c [3];
    logic [63:0] fr_c [3];
    logic [63:0] fprod_c [3];
    fx_t fade_c [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_c[k] = 64'(frac_in[k]) * 64'(frac_in[k]) + HALF;
            fr_c[k] = 64'(fr_reg[0][k]);
            cu_c[k] = 64'(t2_reg[k]) * fr_c[k] + HALF;
            in_c[k] = 64'(t2_reg[k]) * 64'd6 + (64'd10 << FRAC_BITS) - fr_c[k] * 64'd15;
            fprod_c[k] = 64'(t3_reg[k]) * 64'(inner_reg[k]) + HALF;
            fade_c[k] = ((fp_reg[k] >> FRAC_BITS) > 64'(ONE)) ? ONE
                      : 34'(fp_reg[k] >> FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                fr_reg[0][k] <= 34'(frac_in[k]);
                cell_reg[0][k] <= cell_in[k];
                for (int s = 1; s <= GS; s++)
                    fr_reg[s][k] <= fr_reg[s-1][k];
                for (int s = 1; s < 4; s++)
                    cell_reg[s][k] <= cell_reg[s-1][k];
                t2_reg[k]    <= 48'(sq_c[k] >> FRAC_BITS);
                t3_reg[k]    <= 48'(cu_c[k] >> FRAC_BITS);
                inner_reg[k] <= 48'(in_c[k]);
                fp_reg[k]    <= fprod_c[k];
                fade_reg[0][k] <= fade_c[k];
                for (int s = 1; s <= GS; s++)
                    fade_reg[s][k] <= fade_reg[s-1][k];
            end
        end
    end

    // hash level 1: perm[cx], perm[cx+1] (read at stage 0 -> data stage 1)
    logic [7:0] pa_reg, pb_reg;
    // level 2 addresses registered, then perm reads
    idx_t a_reg, b_reg;
    logic [7:0] paa_reg, pab_reg, pba_reg, pbb_reg;
    idx_t aa_reg, ab_reg, ba_reg, bb_reg;
    logic [7:0] h_reg [8];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg <= tab_a[cell_reg[0][0]];
            pb_reg <= tab_a[cell_reg[0][0] + idx_t'(1)];
            a_reg  <= TW'(pa_reg) + cell_reg[1][1];
            b_reg  <= TW'(pb_reg) + cell_reg[1][1];
            paa_reg <= tab_b0[a_reg];
            pab_reg <= tab_b0[a_reg + idx_t'(1)];
            pba_reg <= tab_b1[b_reg];
            pbb_reg <= tab_b1[b_reg + idx_t'(1)];
            aa_reg <= TW'(paa_reg) + cell_reg[3][2];
            ab_reg <= TW'(pab_reg) + cell_reg[3][2];
            ba_reg <= TW'(pba_reg) + cell_reg[3][2];
            bb_reg <= TW'(pbb_reg) + cell_reg[3][2];
            h_reg[0] <= tab_c0[aa_reg];
            h_reg[4] <= tab_c0[aa_reg + idx_t'(1)];
            h_reg[1] <= tab_c1[ba_reg];
            h_reg[5] <= tab_c1[ba_reg + idx_t'(1)];
            h_reg[2] <= tab_c2[ab_reg];
            h_reg[6] <= tab_c2[ab_reg + idx_t'(1)];
            h_reg[3] <= tab_c3[bb_reg];
            h_reg[7] <= tab_c3[bb_reg + idx_t'(1)];
        end
    end

    // h_reg valid at stage 5; gradients registered at stage 6
    logic signed [34:0] g_reg [8];
    fx_t gx, gy, gz, gx1, gy1, gz1;
    assign gx  = fr_reg[GS][0];
    assign gy  = fr_reg[GS][1];
    assign gz  = fr_reg[GS][2];
    assign gx1 = gx - ONE;
    assign gy1 = gy - ONE;
    assign gz1 = gz - ONE;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 8; c++)
                g_reg[c] <= grad_pick(h_reg[c][3:0], c[0] ? gx1 : gx,
                                      c[1] ? gy1 : gy, c[2] ? gz1 : gz);
        end
    end

    // blend levels: a + rnd(f*(b-a))
    function automatic logic signed [35:0] blend_f(input fx_t f,
        input logic signed [35:0] a, input logic signed [35:0] b);
        logic signed [71:0] p;
        begin
            p = 72'(f) * 72'(b - a) + 72'(HALF);
            blend_f = a + 36'(p >>> FRAC_BITS);
        end
    endfunction

    // fade_reg[s] lines up with stage s+3
    logic signed [35:0] l1_reg [4];
    logic signed [35:0] l2_reg [2];
    logic signed [35:0] l3_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
                l1_reg[j] <= blend_f(fade_reg[GS-2][0], 36'(g_reg[2*j]), 36'(g_reg[2*j+1]));
            for (int j = 0; j < 2; j++)
                l2_reg[j] <= blend_f(fade_reg[GS-1][1], l1_reg[2*j], l1_reg[2*j+1]);
            l3_reg <= blend_f(fade_reg[GS][2], l2_reg[0], l2_reg[1]);
        end
    end

    // saturate to +-2.0
    localparam logic signed [35:0] LIM = 36'sd2 <<< FRAC_BITS;
    logic signed [35:0] sat;
    assign sat = (l3_reg > LIM) ? LIM : ((l3_reg < -LIM) ? -LIM : l3_reg);
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = OUT_W'(sat[NW-1:0]);

    `ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `ASSERT_IMPLY(a_rdy, clk, rst_n, !m_tvalid, s_tready, "input blocked with empty output")
    `ASSERT_NEXT(a_load, clk, rst_n, wr_en, !vld_reg[0], "load item made a result")

endmodule

// ===== test/noise_checker.sv =====
// Checker for the 3D gradient noise block: predicts each noise result and compares it
module noise_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [23:0]  m_tdata,
    output int           fail_count,
    output int           pending_count
);
    import gn3d_pkg::*;

    logic [7:0] perm_copy [0:255];
    logic signed [18:0] noise_queue [$];

    // rounded shift by 16 (half up, floor)
    function automatic longint rnd16(input longint p);
        rnd16 = (p + 64'sd32768) >>> 16;
    endfunction

    // quintic fade on a 16-bit fraction
    function automatic longint fade_of(input longint t);
        longint t2, t3, inner, f;
        t2 = (t * t + 32768) >>> 16;
        inner = 6 * t2 + (64'sd10 << 16) - 15 * t;
        t3 = (t2 * t + 32768) >>> 16;
        f = (t3 * inner + 32768) >>> 16;
        if (f > 65536)
            f = 65536;
        fade_of = f;
    endfunction

    function automatic longint lerp(input longint f, input longint a, input longint b);
        lerp = a + rnd16(f * (b - a));
    endfunction

    function automatic longint grad_of(input logic [7:0] hash, input longint x,
                                       input longint y, input longint z);
        logic [3:0] h;
        longint u, v;
        h = hash[3:0];
        u = (h < 8) ? x : y;
        v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        grad_of = (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic logic [7:0] pa(input int i);
        pa = perm_copy[i & 255];
    endfunction

    function automatic logic signed [18:0] noise_of(input logic [31:0] cx_raw,
                                                    input logic [31:0] cy_raw,
                                                    input logic [31:0] cz_raw);
        int cx, cy, cz, a, b, aa, ab, ba, bb;
        longint x, y, z, u, v, w, x1, y1, z1, r;
        cx = cx_raw[23:16]; cy = cy_raw[23:16]; cz = cz_raw[23:16];
        x = cx_raw[15:0]; y = cy_raw[15:0]; z = cz_raw[15:0];
        u = fade_of(x); v = fade_of(y); w = fade_of(z);
        x1 = x - 65536; y1 = y - 65536; z1 = z - 65536;
        a = pa(cx) + cy;
        b = pa(cx + 1) + cy;
        aa = pa(a) + cz;
        ab = pa(a + 1) + cz;
        ba = pa(b) + cz;
        bb = pa(b + 1) + cz;
        r = lerp(w,
            lerp(v, lerp(u, grad_of(pa(aa), x, y, z), grad_of(pa(ba), x1, y, z)),
                    lerp(u, grad_of(pa(ab), x, y1, z), grad_of(pa(bb), x1, y1, z))),
            lerp(v, lerp(u, grad_of(pa(aa + 1), x, y, z1), grad_of(pa(ba + 1), x1, y, z1)),
                    lerp(u, grad_of(pa(ab + 1), x, y1, z1),
                         grad_of(pa(bb + 1), x1, y1, z1))));
        if (r > 131072)
            r = 131072;
        if (r < -131072)
            r = -131072;
        noise_of = r[18:0];
    endfunction

    assign pending_count = noise_queue.size();

    // predict on accepted inputs, compare on accepted outputs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            noise_queue.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_LOAD)
                    perm_copy[s_tdata[7:0]] = s_tdata[15:8];
                else
                    noise_queue.push_back(noise_of(s_tdata[47:16], s_tdata[79:48],
                                                   s_tdata[111:80]));
            end
            if (m_tvalid && m_tready)
            begin
                if (noise_queue.size() == 0)
                begin
                    $display("%0t: unexpected noise result, expected none, actual %h",
                             $time, m_tdata);
                    fail_count <= fail_count + 1;
                end
                else if (m_tdata !== {5'd0, noise_queue[0]})
                begin
                    $display("%0t: noise mismatch, expected %h, actual %h",
                             $time, {5'd0, noise_queue[0]}, m_tdata);
                    fail_count <= fail_count + 1;
                    void'(noise_queue.pop_front());
                end
                else
                    void'(noise_queue.pop_front());
            end
        end
    end
endmodule

// ===== test/tb_top.sv =====
// Testbench top for the 3D gradient noise block: stimulus, idling and verdict
module tb_top;
    import gn3d_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;
    int           fail_count;
    int           pending_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           idle_cycles;
    bit           timed_out;

    gradient_noise_3d DUT (.*);

    noise_checker u_checker (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // receiver stalls at random
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("== FAIL ==");
            $finish;
        end
    end

    // send one item and wait for acceptance; tvalid stays up for the next item
    task automatic send_item(input logic cmd, input logic [7:0] idx, input logic [7:0] val,
                             input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {z, y, x, val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drop tvalid and wait until every expected result has come
    task automatic drain;
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic load_entry(input logic [7:0] idx, input logic [7:0] val);
        send_item(CMD_LOAD, idx, val, $urandom, $urandom, $urandom);
    endtask

    task automatic eval_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        send_item(CMD_EVAL, 8'($urandom), 8'($urandom), x, y, z);
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0: load_entry(8'($urandom), 8'($urandom));
                1: eval_point($urandom_range(1) ? 32'h7fffffff : 32'h80000000,
                              $urandom, {$urandom_range(1) ? 16'hffff : 16'h0000, 16'h0});
                default: eval_point($urandom, $urandom, $urandom);
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = CMD_LOAD;
        s_tdata = '0;
        m_tready = 1'b0;
        timed_out = 1'b0;
        idle_cycles = 0;
        // first the sender idles less than the receiver
        send_idle_pct = 26;
        recv_idle_pct = 45;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill the whole table so no read hits an unwritten entry
        for (int i = 0; i < 256; i++)
            load_entry(8'(i), i == 0 ? 8'hff : 8'($urandom));

        // directed points: field extremes, cell wrap and integer corners
        eval_point(32'h0, 32'h0, 32'h0);
        eval_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        eval_point(32'h80000000, 32'h80000000, 32'h80000000);
        eval_point(32'hffffffff, 32'hffffffff, 32'hffffffff);
        eval_point(32'h00ff8000, 32'h00ffffff, 32'h00ff0001);
        eval_point(32'h00018000, 32'hfffe8000, 32'h00008000);
        eval_point(32'h0000ffff, 32'h00010000, 32'hffff0000);
        eval_point(32'h5555aaaa, 32'haaaa5555, 32'h0f0ff0f0);
        load_entry(8'h00, 8'h00);
        load_entry(8'hff, 8'hff);
        eval_point(32'h00ff0000, 32'h00000000, 32'h00ff4000);

        random_phase(160);

        // pause until every expected result has come
        drain();

        send_idle_pct = 45;
        recv_idle_pct = 26;
        random_phase(160);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(160);

        drain();
        repeat (30) @(negedge clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
